/* hdl/rtc3_pkg.sv */
// types and constants shared by the three-wire rtc serial master
// no dependencies
package rtc3_pkg;

    localparam int CFG_W       = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int TDATA_IN_W  = 80;
    localparam int TDATA_OUT_W = 72;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_BIT_HALF_PERIOD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COMMAND_GAP     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_READ_TURNAROUND = 2'd2;

    // input commands
    localparam logic [2:0] CMD_TICK        = 3'd0;
    localparam logic [2:0] CMD_WRITE       = 3'd1;
    localparam logic [2:0] CMD_READ        = 3'd2;
    localparam logic [2:0] CMD_BURST_WRITE = 3'd3;
    localparam logic [2:0] CMD_BURST_READ  = 3'd4;

    // transaction kinds
    localparam logic [1:0] KIND_WRITE       = 2'd0;
    localparam logic [1:0] KIND_READ        = 2'd1;
    localparam logic [1:0] KIND_BURST_WRITE = 2'd2;
    localparam logic [1:0] KIND_BURST_READ  = 2'd3;

    // command byte bases
    localparam logic [7:0] WRITE_CMD_BASE  = 8'h80;
    localparam logic [7:0] READ_CMD_BASE   = 8'h81;
    localparam logic [7:0] BURST_WRITE_CMD = 8'hBE;
    localparam logic [7:0] BURST_READ_CMD  = 8'hBF;

    typedef enum logic [7:0] {
        PH_IDLE      = 8'b0000_0001,
        PH_CE_GAP    = 8'b0000_0010,
        PH_CMD_LOW   = 8'b0000_0100,
        PH_CMD_HIGH  = 8'b0000_1000,
        PH_MID_GAP   = 8'b0001_0000,
        PH_TURN      = 8'b0010_0000,
        PH_DATA_LOW  = 8'b0100_0000,
        PH_DATA_HIGH = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [CFG_W-1:0] bit_half_period;
        logic [CFG_W-1:0] command_gap;
        logic [CFG_W-1:0] read_turnaround;
    } cfg_t;

    typedef struct packed {
        logic        io_sample;
        logic [63:0] write_data;
        logic [4:0]  reg_addr;
        logic [2:0]  cmd;
    } item_t;

    typedef struct packed {
        logic        done_res;
        logic [63:0] read_data;
        logic        busy_res;
        logic        data_drive;
        logic        data_level;
        logic        clock_level;
        logic        enable_level;
    } result_t;

endpackage

/* hdl/rtc3_cfg_regs.sv */
// timing registers of the three-wire rtc serial master
// depends on rtc3_pkg
module rtc3_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rtc3_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rtc3_pkg::CFG_W-1:0]          cfg_wdata,
    output rtc3_pkg::cfg_t                      cfg
);
    import rtc3_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_BIT_HALF_PERIOD: cfg_next.bit_half_period = cfg_wdata;
                REG_COMMAND_GAP:     cfg_next.command_gap     = cfg_wdata;
                REG_READ_TURNAROUND: cfg_next.read_turnaround = cfg_wdata;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_half_period <= 8'd10;
            cfg_reg.command_gap     <= 8'd30;
            cfg_reg.read_turnaround <= 8'd5;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/rtc3_engine.sv */
// bus sequencer: one tick per step, zero-length waits collapsed into the same tick
// depends on rtc3_pkg
module rtc3_engine #(
    parameter int BURST_BYTES = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  rtc3_pkg::item_t   item,
    input  rtc3_pkg::cfg_t    cfg,
    output rtc3_pkg::result_t result
);
    import rtc3_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [1:0]  kind_reg, kind_next;
    logic [7:0]  tick_reg, tick_next;
    logic [2:0]  bit_reg, bit_next;
    logic [3:0]  byte_reg, byte_next;
    logic [7:0]  shift_reg, shift_next;
    logic [63:0] whold_reg, whold_next;
    logic [63:0] rhold_reg, rhold_next;
    logic        en_reg, en_next;
    logic        clk_reg, clk_next;
    logic        dat_reg, dat_next;
    logic        drv_reg, drv_next;

    logic [7:0]  half;
    logic        expire;
    logic        is_read;
    logic        start;
    logic [1:0]  start_kind;
    logic [2:0]  bit_inc;
    logic [3:0]  byte_inc;
    logic [3:0]  byte_total;
    logic        begin_byte;
    logic [2:0]  begin_idx;
    logic        turn_done;
    logic        done;

    assign half       = (cfg.bit_half_period == 8'd0) ? 8'd1 : cfg.bit_half_period;
    assign expire     = (tick_reg <= 8'd1);
    assign bit_inc    = bit_reg + 3'd1;
    assign byte_inc   = byte_reg + 4'd1;
    assign byte_total = kind_reg[1] ? 4'(BURST_BYTES) : 4'd1;
    assign start      = (phase_reg == PH_IDLE) &&
                        ((item.cmd == CMD_WRITE) || (item.cmd == CMD_READ) ||
                         (item.cmd == CMD_BURST_WRITE) || (item.cmd == CMD_BURST_READ));
    assign start_kind = 2'(item.cmd - 3'd1);
    assign is_read    = start ? start_kind[0] : kind_reg[0];

    always_comb
    begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        byte_next  = byte_reg;
        shift_next = shift_reg;
        whold_next = whold_reg;
        rhold_next = rhold_reg;
        en_next    = en_reg;
        clk_next   = clk_reg;
        dat_next   = dat_reg;
        drv_next   = drv_reg;
        begin_byte = 1'b0;
        begin_idx  = byte_reg[2:0];
        turn_done  = 1'b0;
        done       = 1'b0;

        if (start)
        begin
            kind_next  = start_kind;
            whold_next = item.write_data;
            case (start_kind)
                KIND_WRITE:       shift_next = WRITE_CMD_BASE | {2'b00, item.reg_addr, 1'b0};
                KIND_READ:        shift_next = READ_CMD_BASE | {2'b00, item.reg_addr, 1'b0};
                KIND_BURST_WRITE: shift_next = BURST_WRITE_CMD;
                default:          shift_next = BURST_READ_CMD;
            endcase
            if (is_read)
                rhold_next = 64'd0;
            en_next   = 1'b1;
            clk_next  = 1'b0;
            dat_next  = 1'b1;
            drv_next  = 1'b1;
            bit_next  = 3'd0;
            byte_next = 4'd0;
            if (cfg.command_gap == 8'd0)
            begin
                dat_next   = shift_next[0];
                phase_next = PH_CMD_LOW;
                tick_next  = half;
            end
            else
            begin
                phase_next = PH_CE_GAP;
                tick_next  = cfg.command_gap;
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            tick_next = tick_reg - 8'd1;
            if (expire)
            begin
                case (phase_reg)
                    PH_CE_GAP:
                    begin
                        bit_next   = 3'd0;
                        drv_next   = 1'b1;
                        dat_next   = shift_reg[0];
                        clk_next   = 1'b0;
                        phase_next = PH_CMD_LOW;
                        tick_next  = half;
                    end
                    PH_CMD_LOW:
                    begin
                        clk_next   = 1'b1;
                        phase_next = PH_CMD_HIGH;
                        tick_next  = half;
                    end
                    PH_DATA_LOW:
                    begin
                        if (is_read && item.io_sample)
                            shift_next[bit_reg] = 1'b1;
                        clk_next   = 1'b1;
                        phase_next = PH_DATA_HIGH;
                        tick_next  = half;
                    end
                    PH_CMD_HIGH:
                    begin
                        clk_next = 1'b0;
                        if (bit_reg != 3'd7)
                        begin
                            bit_next   = bit_inc;
                            dat_next   = shift_reg[bit_inc];
                            phase_next = PH_CMD_LOW;
                            tick_next  = half;
                        end
                        else
                        begin
                            dat_next  = 1'b1;
                            byte_next = 4'd0;
                            if (cfg.command_gap != 8'd0)
                            begin
                                phase_next = PH_MID_GAP;
                                tick_next  = cfg.command_gap;
                            end
                            else
                            begin
                                begin_byte = 1'b1;
                                begin_idx  = 3'd0;
                            end
                        end
                    end
                    PH_MID_GAP:
                    begin
                        begin_byte = 1'b1;
                        begin_idx  = byte_reg[2:0];
                    end
                    PH_TURN:
                    begin
                        turn_done = 1'b1;
                    end
                    PH_DATA_HIGH:
                    begin
                        clk_next = 1'b0;
                        if (bit_reg != 3'd7)
                        begin
                            bit_next = bit_inc;
                            if (!is_read)
                                dat_next = shift_reg[bit_inc];
                            phase_next = PH_DATA_LOW;
                            tick_next  = half;
                        end
                        else
                        begin
                            if (is_read)
                                rhold_next[{byte_reg[2:0], 3'b000} +: 8] = shift_reg;
                            drv_next  = 1'b1;
                            dat_next  = 1'b1;
                            byte_next = byte_inc;
                            if (byte_inc < byte_total)
                            begin
                                begin_byte = 1'b1;
                                begin_idx  = byte_inc[2:0];
                            end
                            else
                            begin
                                en_next    = 1'b0;
                                phase_next = PH_IDLE;
                                tick_next  = 8'd0;
                                bit_next   = 3'd0;
                                byte_next  = 4'd0;
                                done       = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        tick_next  = 8'd0;
                    end
                endcase
            end
        end

        if (begin_byte)
        begin
            if (is_read)
            begin
                drv_next = 1'b0;
                dat_next = 1'b1;
                if (cfg.read_turnaround != 8'd0)
                begin
                    phase_next = PH_TURN;
                    tick_next  = cfg.read_turnaround;
                end
                else
                begin
                    turn_done = 1'b1;
                end
            end
            else
            begin
                shift_next = whold_reg[{begin_idx, 3'b000} +: 8];
                bit_next   = 3'd0;
                drv_next   = 1'b1;
                dat_next   = shift_next[0];
                phase_next = PH_DATA_LOW;
                tick_next  = half;
            end
        end

        if (turn_done)
        begin
            shift_next = 8'd0;
            bit_next   = 3'd0;
            clk_next   = 1'b0;
            phase_next = PH_DATA_LOW;
            tick_next  = half;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            kind_reg  <= 2'd0;
            tick_reg  <= 8'd0;
            bit_reg   <= 3'd0;
            byte_reg  <= 4'd0;
            shift_reg <= 8'd0;
            whold_reg <= 64'd0;
            rhold_reg <= 64'd0;
            en_reg    <= 1'b0;
            clk_reg   <= 1'b0;
            dat_reg   <= 1'b1;
            drv_reg   <= 1'b1;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            byte_reg  <= byte_next;
            shift_reg <= shift_next;
            whold_reg <= whold_next;
            rhold_reg <= rhold_next;
            en_reg    <= en_next;
            clk_reg   <= clk_next;
            dat_reg   <= dat_next;
            drv_reg   <= drv_next;
        end
    end

    assign result.enable_level = en_next;
    assign result.clock_level  = clk_next;
    assign result.data_level   = dat_next;
    assign result.data_drive   = drv_next;
    assign result.busy_res     = (phase_next != PH_IDLE);
    assign result.read_data    = rhold_next;
    assign result.done_res     = done;

    // released data line always reads back as high
    assert property (@(posedge clk) disable iff (!rst_n) !drv_reg |-> dat_reg)
        else $error("data released but drive level low");

    // chip enable tracks an active transaction
    assert property (@(posedge clk) disable iff (!rst_n) en_reg == (phase_reg != PH_IDLE))
        else $error("chip enable out of step with phase");

    // an active phase always has ticks left to wait
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> (tick_reg != 8'd0))
        else $error("active phase with zero tick count");

    // serial clock only toggles inside a transaction
    assert property (@(posedge clk) disable iff (!rst_n) clk_reg |-> en_reg)
        else $error("serial clock high with enable low");

endmodule

/* hdl/three_wire_rtc_serial_master_core.sv */
// three-wire rtc serial master: input register, sequencer and result register
// depends on rtc3_pkg, rtc3_cfg_regs, rtc3_engine
//
// each input transaction is one timing tick. it carries a command (tick only, single
// write, single read, burst write, burst read), a register address, eight write bytes
// and the sampled level of the data pin. every input transaction gives exactly one
// output transaction with the pin levels after that tick, busy, done and the bytes
// read so far.
// an accepted transaction is held in the input register, then the sequencer update is
// stored in the result register; throughput is one transaction per cycle while the
// output is not stalled, since the sequencer updates once per step between the input
// register and the result register.
// timing registers are written through cfg_we, cfg_index and cfg_wdata; the user
// writes them only while the block is idle, unenforced by the block; index 0 half
// period, 1 command gap, 2 read turnaround, others ignored. reset clears both pipeline
// registers, loads the timing defaults (10, 30, 5), leaves enable and clock low and
// the data pin driven high. a stalled output holds its result; the input register
// fills and then s_axis_tready drops until the receiver takes the waiting transaction.
module three_wire_rtc_serial_master_core #(
    parameter int BURST_BYTES = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // cmd[2:0], reg_addr[7:3], write_data[71:8], io_sample[72], zero[79:73]
    input  logic [rtc3_pkg::TDATA_IN_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // enable_level[0], clock_level[1], data_level[2], data_drive[3], busy_res[4],
    // read_data[68:5], done_res[69], zero[71:70]
    output logic [rtc3_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,
    input  logic                                cfg_we,
    input  logic [rtc3_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rtc3_pkg::CFG_W-1:0]          cfg_wdata
);
    import rtc3_pkg::*;

    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg;
    logic    step;
    logic    in_fire;
    cfg_t    cfg;
    result_t res;

    assign step          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_fire)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            in_item_reg <= item_t'(s_axis_tdata[$bits(item_t)-1:0]);
        if (step)
            out_res_reg <= res;
    end

    rtc3_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rtc3_engine #(
        .BURST_BYTES (BURST_BYTES)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(TDATA_OUT_W - $bits(result_t))'(0), out_res_reg};

    // completion is reported with the bus already released
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.done_res) |->
        (!out_res_reg.busy_res && !out_res_reg.enable_level))
        else $error("done reported while still busy");

    // a stalled result is not overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> (out_valid_reg && $stable(out_res_reg)))
        else $error("stalled result changed");

    // an item waits in the input register only while the output is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !step) |-> (out_valid_reg && !m_axis_tready))
        else $error("input held without output stall");

endmodule
